// ===== sv/abbc_pkg.sv =====
// ----------------------------------------------------------------------------
// abbc_pkg
// Shared widths, register indexes and types for the alpha bounding box crop
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package abbc_pkg;

    // Largest frame dimension, in pixels, along either axis.
    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = $clog2(MAX_DIM);   // column or row position
    localparam int DIM_W      = 13;                // size registers and box extents
    localparam int ALPHA_W    = 8;
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 8;
    localparam int BOX_BITS   = 2 * COORD_W + 2 * DIM_W;
    localparam int OUT_DATA_W = ((BOX_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd2;

    // Register reset values.
    localparam logic [THR_W-1:0] THR_RESET = '0;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // One result of a finished frame.
    typedef struct packed {
        logic               any_found;
        logic [DIM_W-1:0]   box_height;
        logic [DIM_W-1:0]   box_width;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_left;
    } t_box;

    // Per-cycle command from the top level to the extent tracker.
    typedef struct packed {
        logic advance;   // a buffered pixel is consumed this cycle
        logic opaque;    // that pixel meets the threshold
    } t_trk_ctrl;

    // A size of zero behaves as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/abbc_extent.sv =====
// ----------------------------------------------------------------------------
// abbc_extent
// Raster position counters and the running extent of opaque pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module abbc_extent
    import abbc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_trk_ctrl        i_ctrl,
    input  wire logic [DIM_W-1:0] i_width,    // effective frame width
    input  wire logic [DIM_W-1:0] i_height,   // effective frame height
    output logic                  o_last,     // current position ends the frame
    output t_box                  o_box       // result if this pixel ends the frame
);

    logic [COORD_W-1:0] r_col, r_row;
    logic [COORD_W-1:0] r_lc, r_lr, r_gc, r_gr;
    logic               r_seen;

    logic [COORD_W-1:0] n_lc, n_lr, n_gc, n_gr;
    logic               n_seen;
    logic               w_col_last, w_row_last;

    // A row ends once col + 1 reaches the width; this also catches counters
    // that sit beyond a size shrunk in mid-frame.
    assign w_col_last = ({1'b0, r_col} + DIM_W'(1)) >= i_width;
    assign w_row_last = ({1'b0, r_row} + DIM_W'(1)) >= i_height;
    assign o_last     = w_col_last && w_row_last;

    always_comb begin
        n_lc   = r_lc;
        n_lr   = r_lr;
        n_gc   = r_gc;
        n_gr   = r_gr;
        n_seen = r_seen;
        if (i_ctrl.opaque) begin
            n_seen = 1'b1;
            if (!r_seen) begin
                n_lc = r_col;
                n_gc = r_col;
                n_lr = r_row;
                n_gr = r_row;
            end else begin
                if (r_col < r_lc) n_lc = r_col;
                if (r_col > r_gc) n_gc = r_col;
                if (r_row < r_lr) n_lr = r_row;
                if (r_row > r_gr) n_gr = r_row;
            end
        end
    end

    always_comb begin
        o_box = '0;
        if (n_seen) begin
            o_box.any_found  = 1'b1;
            o_box.box_left   = n_lc;
            o_box.box_top    = n_lr;
            o_box.box_width  = {1'b0, n_gc} - {1'b0, n_lc} + DIM_W'(1);
            o_box.box_height = {1'b0, n_gr} - {1'b0, n_lr} + DIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_seen <= 1'b0;
        end else if (i_ctrl.advance) begin
            if (w_col_last) begin
                r_col <= '0;
                r_row <= w_row_last ? '0 : r_row + COORD_W'(1);
            end else begin
                r_col <= r_col + COORD_W'(1);
            end
            r_seen <= o_last ? 1'b0 : n_seen;
        end
    end

    // Extents are only read once the seen flag is set, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_lc <= n_lc;
            r_lr <= n_lr;
            r_gc <= n_gc;
            r_gr <= n_gr;
        end
    end

endmodule

`default_nettype wire

// ===== sv/alpha_bounding_box_crop_unit.sv =====
// ----------------------------------------------------------------------------
// alpha_bounding_box_crop_unit
// Finds the rectangle that encloses every pixel of a frame whose alpha meets
// a programmable threshold, and reports it once per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  ---------------------------------------------------
//  s_axis    in         tdata[7:0] alpha, one pixel per transfer, raster order
//  m_axis    out        tdata box_left/top/width/height, tuser any_found
//  cfg       in         write-only: threshold, frame width, frame height
//
// Each pixel waits in an input register and is folded into the running
// extent when it leaves it, so one pixel is taken per clock unless the
// input side stalls. The result of a frame's last pixel is loaded from there
// into the output register that drives m_axis. The input side stalls only
// when a frame ends while the previous result still waits in the output
// register. Reset (synchronous, active low) clears the position counters and
// the found flag and loads the register defaults: threshold 0, width and height 4096.
//
// The position is counted internally from the configured frame size; there
// is no start-of-frame or end-of-line marker on the input. A size of zero
// acts as one and a size above 4096 acts as 4096. Configuration writes
// never restart a frame in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_bounding_box_crop_unit
    import abbc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Pixel input.
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [7:0] alpha

    // Result output.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // [11:0] box_left,
                                                         // [23:12] box_top,
                                                         // [36:24] box_width,
                                                         // [49:37] box_height,
                                                         // upper bits zero
    output logic                       o_m_axis_tuser,   // [0] any_found

    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [THR_W-1:0]   r_thr;
    logic [DIM_W-1:0]   r_frame_w;
    logic [DIM_W-1:0]   r_frame_h;

    // Input register.
    logic               r_in_valid;
    logic [ALPHA_W-1:0] r_in_alpha;

    // Output register.
    logic               r_out_valid;
    t_box               r_out_box;

    t_trk_ctrl          w_ctrl;
    t_box               w_box;
    logic               w_last;
    logic               w_out_blocked;
    logic               w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RESET;
            r_frame_w <= DIM_RESET;
            r_frame_h <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                CFG_FRAME_WIDTH:     r_frame_w <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:    r_frame_h <= i_cfg_data[DIM_W-1:0];
                default: ;  // unused index: the write is dropped
            endcase
        end
    end

    // The buffered pixel moves on unless it ends a frame while the output
    // register is still holding a result that is not being taken.
    assign w_out_blocked   = r_out_valid && !i_m_axis_tready;
    assign w_advance       = r_in_valid && !(w_last && w_out_blocked);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    assign w_ctrl.advance = w_advance;
    assign w_ctrl.opaque  = {1'b0, r_in_alpha} >= r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_alpha <= i_s_axis_tdata[ALPHA_W-1:0];
        end
    end

    abbc_extent u_extent (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_width  (clamp_dim(r_frame_w)),
        .i_height (clamp_dim(r_frame_h)),
        .o_last   (w_last),
        .o_box    (w_box)
    );

    // A finished frame loads the output register; a transfer on m_axis
    // empties it. Both in one cycle is fine: the load wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_last) begin
            r_out_box <= w_box;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - BOX_BITS){1'b0}},
                              r_out_box.box_height, r_out_box.box_width,
                              r_out_box.box_top, r_out_box.box_left};
    assign o_m_axis_tuser  = r_out_box.any_found;

endmodule

`default_nettype wire

// ===== sv/abbc_checker.sv =====
// ----------------------------------------------------------------------------
// abbc_checker
// Port-level checks on the alpha bounding box crop unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module abbc_checker
    import abbc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tuser
);

    logic [COORD_W-1:0] w_left, w_top;
    logic [DIM_W-1:0]   w_width, w_height;

    assign w_left   = o_m_axis_tdata[COORD_W-1:0];
    assign w_top    = o_m_axis_tdata[2*COORD_W-1:COORD_W];
    assign w_width  = o_m_axis_tdata[2*COORD_W+DIM_W-1:2*COORD_W];
    assign w_height = o_m_axis_tdata[BOX_BITS-1:2*COORD_W+DIM_W];

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // The pixel input can only stall while a result waits and is not taken.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid || i_m_axis_tready |-> o_s_axis_tready)
        else $error("pixel input stalled with the output free");

    // An empty frame reports an all-zero rectangle.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("empty frame with nonzero rectangle");

    // A found rectangle is never degenerate.
    a_found_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> w_width != '0 && w_height != '0)
        else $error("found rectangle has zero extent");

    // A found rectangle stays inside the largest frame.
    a_found_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            ({1'b0, w_left} + w_width) <= DIM_W'(MAX_DIM)
            && ({1'b0, w_top} + w_height) <= DIM_W'(MAX_DIM))
        else $error("rectangle exceeds frame bounds");

endmodule

bind alpha_bounding_box_crop_unit abbc_checker u_abbc_checker (.*);

`default_nettype wire

// ===== sim/tb_alpha_bounding_box_crop_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alpha_bounding_box_crop_unit
// Self-checking bench for the alpha bounding box crop unit. A short table of
// hand-picked frames comes first, then randomized frames under three
// handshake idling patterns, all scored against a cycle-free predictor of
// the extent tracking.
// ----------------------------------------------------------------------------

module tb_alpha_bounding_box_crop_unit;
    import abbc_pkg::*;

    // Longest stretch without any transfer before the run is declared hung.
    // The deliberate output stall below is far shorter than this.
    localparam int QUIET_LIMIT    = 2000;
    // Cycles allowed after the last result before the unit counts as idle.
    // It covers the pixel register and the output register.
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int ITEMS_PER_MODE = 375;
    localparam int MAX_PRINTED    = 40;

    // One row of the directed table. Each row optionally reprograms the
    // registers (wr holds one bit per register index), then sends npix
    // pixels: the pixel at raster offset dot gets alpha fg, all others bg.
    // Where typed is set, the result of the row is written out by hand.
    typedef struct {
        logic [2:0]            wr;
        logic [CFG_DATA_W-1:0] thr_data;
        logic [CFG_DATA_W-1:0] wid_data;
        logic [CFG_DATA_W-1:0] hgt_data;
        int                    npix;
        logic [ALPHA_W-1:0]    fg;
        logic [ALPHA_W-1:0]    bg;
        int                    dot;
        bit                    typed;
        t_box                  want;
    } t_seg;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_ALPHA_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the registers and of the per-frame extent state.
    // Reset is applied once, so the declared values are the reset values.
    logic [THR_W-1:0]   thr_reg     = THR_RESET;
    logic [DIM_W-1:0]   width_reg   = DIM_RESET;
    logic [DIM_W-1:0]   height_reg  = DIM_RESET;
    logic [COORD_W-1:0] col_pos     = '0;
    logic [COORD_W-1:0] row_pos     = '0;
    logic [COORD_W-1:0] col_lo      = '0;
    logic [COORD_W-1:0] row_lo      = '0;
    logic [COORD_W-1:0] col_hi      = '0;
    logic [COORD_W-1:0] row_hi      = '0;
    bit                 seen_opaque = 1'b0;

    // Boxes predicted for frames whose last pixel has been accepted.
    t_box pending_boxes[$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int holdoff_req  = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;
    int errors       = 0;
    int pixels_sent  = 0;
    int mode_items   = 0;
    int reg_writes   = 0;
    int boxes_seen   = 0;
    int boxes_found  = 0;

    t_seg dir_tab [10];

    always #1 clk = ~clk;

    alpha_bounding_box_crop_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] alpha
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [11:0] left, [23:12] top, [36:24] width,
                                       // [49:37] height, rest zero
        .o_m_axis_tuser  (m_tuser),    // [0] any_found
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    function automatic t_box mk_box(input int l, input int t, input int w, input int h,
                                    input int f);
        t_box b;
        b.box_left   = COORD_W'(l);
        b.box_top    = COORD_W'(t);
        b.box_width  = DIM_W'(w);
        b.box_height = DIM_W'(h);
        b.any_found  = 1'(f);
        return b;
    endfunction

    // A programmed size of zero means one pixel; anything past the largest
    // supported dimension is held at that dimension.
    function automatic int eff_size(input logic [DIM_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > MAX_DIM) n = MAX_DIM;
        return n;
    endfunction

    // Folds one accepted pixel into the running extent. The position is
    // compared against the current size each time, so counters left beyond
    // a shrunken frame close the row or frame on the very next pixel.
    function automatic void fold_pixel(input logic [ALPHA_W-1:0] a, output bit done,
                                       output t_box res);
        done = 1'b0;
        res  = '0;
        if ({1'b0, a} >= thr_reg) begin
            if (!seen_opaque) begin
                col_lo      = col_pos;
                col_hi      = col_pos;
                row_lo      = row_pos;
                row_hi      = row_pos;
                seen_opaque = 1'b1;
            end else begin
                if (col_pos < col_lo) col_lo = col_pos;
                if (col_pos > col_hi) col_hi = col_pos;
                if (row_pos < row_lo) row_lo = row_pos;
                if (row_pos > row_hi) row_hi = row_pos;
            end
        end
        if (int'(col_pos) + 1 < eff_size(width_reg)) begin
            col_pos = col_pos + 1'b1;
        end else begin
            col_pos = '0;
            if (int'(row_pos) + 1 < eff_size(height_reg)) begin
                row_pos = row_pos + 1'b1;
            end else begin
                done = 1'b1;
                if (seen_opaque) begin
                    res.box_left   = col_lo;
                    res.box_top    = row_lo;
                    res.box_width  = DIM_W'(int'(col_hi) - int'(col_lo) + 1);
                    res.box_height = DIM_W'(int'(row_hi) - int'(row_lo) + 1);
                    res.any_found  = 1'b1;
                end
                row_pos     = '0;
                col_lo      = '0;
                row_lo      = '0;
                col_hi      = '0;
                row_hi      = '0;
                seen_opaque = 1'b0;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("[%0t] box %0d: %s is %0d, expected %0d", $time, boxes_seen, what,
                     got, want);
        end
    endtask

    // Offers one pixel, with random idle cycles ahead of it, and holds it
    // until the unit takes it. On acceptance the predictor advances and any
    // finished frame queues its box (or the hand-written one for table rows).
    task automatic send_pixel(input logic [ALPHA_W-1:0] a, input bit use_typed,
                              input t_box typed_box);
        bit   done;
        t_box res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        do @(posedge clk); while (!s_tready);
        fold_pixel(a, done, res);
        if (done) pending_boxes.insert(pending_boxes.size(), use_typed ? typed_box : res);
        pixels_sent++;
    endtask

    // Stops offering pixels and waits until every predicted box has been
    // delivered and the last pixel has certainly left the pipeline.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_boxes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_ALPHA_THRESHOLD: thr_reg    = data[THR_W-1:0];
            CFG_FRAME_WIDTH:     width_reg  = data;
            CFG_FRAME_HEIGHT:    height_reg = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Registers are only touched once the unit has gone quiet. The frame
    // state is left alone, so a write may land in the middle of a frame.
    task automatic program_regs(input logic [2:0] mask, input logic [CFG_DATA_W-1:0] thr_d,
                                input logic [CFG_DATA_W-1:0] wid_d,
                                input logic [CFG_DATA_W-1:0] hgt_d);
        if (mask != '0) begin
            settle();
            if (mask[CFG_ALPHA_THRESHOLD]) write_reg(CFG_ALPHA_THRESHOLD, thr_d);
            if (mask[CFG_FRAME_WIDTH])     write_reg(CFG_FRAME_WIDTH, wid_d);
            if (mask[CFG_FRAME_HEIGHT])    write_reg(CFG_FRAME_HEIGHT, hgt_d);
            cfg_we <= 1'b0;
        end
    endtask

    // Random pixels biased around the current threshold: pct_opaque percent
    // of them meet it, the rest fall short, and one in ten is fully random.
    task automatic send_frame_pixels(input int n, input int pct_opaque, input bit counted);
        logic [ALPHA_W-1:0] a;
        int                 k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                a = ALPHA_W'($urandom_range(0, 255));
            end else if ($urandom_range(0, 99) < pct_opaque) begin
                a = (thr_reg > 255) ? ALPHA_W'($urandom_range(0, 255))
                                    : ALPHA_W'($urandom_range(int'(thr_reg), 255));
            end else if (thr_reg == 0) begin
                a = ALPHA_W'($urandom_range(0, 255));
            end else begin
                a = ALPHA_W'($urandom_range(0, (thr_reg > 255) ? 255 : int'(thr_reg) - 1));
            end
            send_pixel(a, 1'b0, '0);
            if (counted) mode_items++;
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request so the
    // output register fills and the unit has to stall its pixel input.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_seen != holdoff_req) begin
            m_tready     <= 1'b0;
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Result checker: every box transfer is compared field by field with
    // the oldest predicted box.
    always @(posedge clk) begin
        t_box got;
        t_box want;
        if (rst_n && m_tvalid && m_tready) begin
            got.box_left   = m_tdata[COORD_W-1:0];
            got.box_top    = m_tdata[2*COORD_W-1:COORD_W];
            got.box_width  = m_tdata[2*COORD_W+DIM_W-1:2*COORD_W];
            got.box_height = m_tdata[BOX_BITS-1:2*COORD_W+DIM_W];
            got.any_found  = m_tuser;
            boxes_seen++;
            if (got.any_found) boxes_found++;
            if (pending_boxes.size() == 0) begin
                report_mismatch("box with no frame pending", 1, 0);
            end else begin
                want = pending_boxes.pop_front();
                if (got.box_left != want.box_left)
                    report_mismatch("box_left", got.box_left, want.box_left);
                if (got.box_top != want.box_top)
                    report_mismatch("box_top", got.box_top, want.box_top);
                if (got.box_width != want.box_width)
                    report_mismatch("box_width", got.box_width, want.box_width);
                if (got.box_height != want.box_height)
                    report_mismatch("box_height", got.box_height, want.box_height);
                if (got.any_found != want.any_found)
                    report_mismatch("any_found", got.any_found, want.any_found);
                if ((m_tdata >> BOX_BITS) != '0)
                    report_mismatch("tdata padding", m_tdata >> BOX_BITS, 0);
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles without a transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d boxes outstanding",
                         QUIET_LIMIT, pending_boxes.size());
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [2:0]            mask;
        logic [CFG_DATA_W-1:0] thr_d;
        logic [CFG_DATA_W-1:0] wid_d;
        logic [CFG_DATA_W-1:0] hgt_d;
        int                    mode;
        int                    ph;
        int                    k;
        int                    roll;
        int                    area;
        int                    n;
        int                    pct;

        // Directed frames. The first row runs on the reset sizes (4096 wide)
        // and the second shrinks the frame under it, so the row ends on the
        // counters already reached. Later rows cover a threshold above 255,
        // the exact-threshold boundary, zero sizes acting as one, threshold
        // register bits beyond its width, and a width cut mid-frame.
        dir_tab = '{
            '{3'b000, 13'd0,    13'd0, 13'd0, 2, 8'd0,   8'd0,   -1, 1'b0,
              mk_box(0, 0, 0, 0, 0)},
            '{3'b110, 13'd0,    13'd3, 13'd1, 1, 8'd0,   8'd0,   -1, 1'b1,
              mk_box(0, 0, 3, 1, 1)},
            '{3'b111, 13'd256,  13'd2, 13'd2, 4, 8'd255, 8'd255, -1, 1'b1,
              mk_box(0, 0, 0, 0, 0)},
            '{3'b001, 13'd255,  13'd0, 13'd0, 4, 8'd255, 8'd254,  3, 1'b1,
              mk_box(1, 1, 1, 1, 1)},
            '{3'b111, 13'd0,    13'd0, 13'd0, 1, 8'd0,   8'd0,   -1, 1'b1,
              mk_box(0, 0, 1, 1, 1)},
            '{3'b001, 13'd1,    13'd0, 13'd0, 1, 8'd0,   8'd0,   -1, 1'b1,
              mk_box(0, 0, 0, 0, 0)},
            '{3'b111, 13'h1FFF, 13'd1, 13'd3, 3, 8'd255, 8'd255, -1, 1'b1,
              mk_box(0, 0, 0, 0, 0)},
            '{3'b111, 13'd128,  13'd3, 13'd2, 6, 8'd128, 8'd127,  4, 1'b1,
              mk_box(1, 1, 1, 1, 1)},
            '{3'b111, 13'd0,    13'd4, 13'd2, 5, 8'd255, 8'd255, -1, 1'b0,
              mk_box(0, 0, 0, 0, 0)},
            '{3'b010, 13'd0,    13'd1, 13'd0, 1, 8'd0,   8'd0,   -1, 1'b1,
              mk_box(0, 0, 4, 2, 1)}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 27;
        rx_idle_pct = 75;
        foreach (dir_tab[r]) begin
            program_regs(dir_tab[r].wr, dir_tab[r].thr_data, dir_tab[r].wid_data,
                         dir_tab[r].hgt_data);
            for (k = 0; k < dir_tab[r].npix; k++) begin
                send_pixel((k == dir_tab[r].dot) ? dir_tab[r].fg : dir_tab[r].bg,
                           dir_tab[r].typed, dir_tab[r].want);
            end
        end

        // Random part in three idling patterns. Each phase picks new
        // register values and sends a few frames; a quarter of the phases
        // stop part way into a frame so the next write lands mid-frame.
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin tx_idle_pct = 27; rx_idle_pct = 75; end
                1: begin tx_idle_pct = 75; rx_idle_pct = 27; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            mode_items = 0;
            ph         = 0;
            while (mode_items < ITEMS_PER_MODE) begin
                if (mode == 2 && ph == 1) begin
                    // Single-pixel frames back to back while the receiver
                    // holds off: the result register fills and input stalls.
                    program_regs(3'b110, '0, 13'd1, 13'd1);
                    holdoff_req <= holdoff_req + 1;
                    send_frame_pixels(64, 50, 1'b1);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10)      thr_d = '0;
                    else if (roll < 22) thr_d = CFG_DATA_W'($urandom_range(256, 8191));
                    else                thr_d = CFG_DATA_W'($urandom_range(0, 255));
                    wid_d = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(9, 48))
                                                        : CFG_DATA_W'($urandom_range(0, 8));
                    hgt_d = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(7, 24))
                                                        : CFG_DATA_W'($urandom_range(0, 6));
                    mask = 3'($urandom_range(1, 7));
                    program_regs(mask, thr_d, wid_d, hgt_d);
                    area = eff_size(width_reg) * eff_size(height_reg);
                    n    = (area > 100) ? area : area * $urandom_range(1, 3);
                    if ($urandom_range(0, 3) == 0) n += $urandom_range(0, area - 1);
                    // Keep the pattern to its share of pixels; a frame cut
                    // short here simply continues under the next phase.
                    if (n > ITEMS_PER_MODE - mode_items) n = ITEMS_PER_MODE - mode_items;
                    case ($urandom_range(0, 4))
                        0: pct = 0;
                        1: pct = 3;
                        2: pct = 15;
                        3: pct = 50;
                        default: pct = 100;
                    endcase
                    send_frame_pixels(n, pct, 1'b1);
                end
                ph++;
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_boxes.size() != 0)
            report_mismatch("boxes never delivered", pending_boxes.size(), 0);

        $display("Covered %0d pixels and %0d register writes; %0d boxes checked, %0d found.",
                 pixels_sent, reg_writes, boxes_seen, boxes_found);
        $display("Included clamped sizes, out-of-range thresholds, mid-frame resizing, %0s",
                 "and a long output stall.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
